FILE: hdl/efwd_pkg.sv
// Package for the earliest-free worker dispatch block.
// Holds the request and response payload types and the shared constants.
// No dependencies.
`default_nettype none
package efwd_pkg;

   localparam int WORKERS_DEFAULT = 16;
   localparam int TIME_W          = 48;
   localparam int DUR_W           = 32;
   localparam int ACTIVE_W        = 5;
   localparam int WORKER_W        = 4;

   localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = ACTIVE_W'(16);
   localparam logic [TIME_W-1:0]   TIME_MAX     = {TIME_W{1'b1}};

   typedef struct packed {
      logic [DUR_W-1:0] duration;
      logic             new_batch;
   } req_type;

   typedef struct packed {
      logic [WORKER_W-1:0] worker;
      logic [TIME_W-1:0]   start_time;
      logic                saturated;
   } rsp_type;

endpackage
`default_nettype wire

FILE: hdl/efwd_cell.sv
// One worker cell of the dispatch chain: holds the worker's free time and
// forwards the running earliest-free candidate to its neighbor.
// Depends on efwd_pkg.
`default_nettype none
module efwd_cell #(
   parameter int WORKERS = efwd_pkg::WORKERS_DEFAULT,
   parameter int INDEX   = 0,
   parameter int IW      = (WORKERS > 1) ? $clog2(WORKERS) : 1
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic [efwd_pkg::ACTIVE_W-1:0] active_workers,
   input  wire logic                          tok_in_valid,
   input  wire logic [IW-1:0]                 tok_in_idx,
   input  wire logic [efwd_pkg::TIME_W-1:0]   tok_in_time,
   output logic                               tok_out_valid,
   output logic [IW-1:0]                      tok_out_idx,
   output logic [efwd_pkg::TIME_W-1:0]        tok_out_time,
   input  wire logic                          clear,
   input  wire logic                          wr_en,
   input  wire logic [IW-1:0]                 wr_idx,
   input  wire logic [efwd_pkg::TIME_W-1:0]   wr_time
);
   import efwd_pkg::*;

   localparam logic [IW-1:0]       MY_IDX    = IW'(INDEX);
   localparam bit                  IN_RANGE  = (INDEX < (1 << ACTIVE_W));
   localparam logic [ACTIVE_W-1:0] MY_IDX_AW = ACTIVE_W'(INDEX);

   logic [TIME_W-1:0] free_ff, free_in;
   logic              valid_ff, valid_in;
   logic [IW-1:0]     idx_ff, idx_in;
   logic [TIME_W-1:0] time_ff, time_in;
   logic              active;
   logic              take;

   always_comb begin
      active = (INDEX == 0) || (IN_RANGE && (MY_IDX_AW < active_workers));
      take   = active && ((INDEX == 0) || (free_ff < tok_in_time));

      free_in = free_ff;
      if (clear) begin
         free_in = '0;
      end else if (wr_en && (wr_idx == MY_IDX)) begin
         free_in = wr_time;
      end

      valid_in = tok_in_valid;
      idx_in   = take ? MY_IDX : tok_in_idx;
      time_in  = take ? free_ff : tok_in_time;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         free_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         free_ff  <= free_in;
         valid_ff <= valid_in;
      end
      idx_ff  <= idx_in;
      time_ff <= time_in;
   end

   assign tok_out_valid = valid_ff;
   assign tok_out_idx   = idx_ff;
   assign tok_out_time  = time_ff;

endmodule
`default_nettype wire

FILE: hdl/earliest_free_worker_dispatch_top.sv
// Top level of the earliest-free worker dispatch block.
// Builds the chain of efwd_cell worker cells and the dispatch control.
// Depends on efwd_pkg and efwd_cell.
//
// A job is taken when start is high and busy is low. After the transfer the
// candidate is registered and walks the chain one worker cell per cycle
// comparing free times; at the end of the chain the duration is added, and
// the winner's new free time is written back and the result registered at
// the same edge. busy stays high until that edge, so the next job can be
// taken at the edge that ends the result cycle. The result appears on
// rsp_payload for exactly one cycle with rsp_valid high; the receiver
// cannot stall it. The worker count register takes a write whenever
// csr_valid is high (csr_ready is always high) and must only be written
// while busy is low.
`default_nettype none
module earliest_free_worker_dispatch_top #(
   parameter int WORKERS = efwd_pkg::WORKERS_DEFAULT
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire efwd_pkg::req_type             req_payload,
   output logic                               rsp_valid,
   output efwd_pkg::rsp_type                  rsp_payload,
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [efwd_pkg::ACTIVE_W-1:0] csr_data
);
   import efwd_pkg::*;

   localparam int IW = (WORKERS > 1) ? $clog2(WORKERS) : 1;

   logic                busy_ff, busy_in;
   logic                launch_ff, launch_in;
   logic [DUR_W-1:0]    dur_ff, dur_in;
   logic [ACTIVE_W-1:0] active_ff, active_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_ff, rsp_in;

   logic                accept;
   logic                clear;
   logic                finish;
   logic [TIME_W:0]     sum;
   logic [TIME_W-1:0]   new_time;
   logic [WORKER_W-1:0] worker_out;

   logic              tok_valid [WORKERS+1];
   logic [IW-1:0]     tok_idx   [WORKERS+1];
   logic [TIME_W-1:0] tok_time  [WORKERS+1];

   assign tok_valid[0] = launch_ff;
   assign tok_idx[0]   = '0;
   assign tok_time[0]  = '0;

   for (genvar g = 0; g < WORKERS; g++) begin : g_cell
      efwd_cell #(
         .WORKERS (WORKERS),
         .INDEX   (g),
         .IW      (IW)
      ) u_cell (
         .clock          (clock),
         .reset          (reset),
         .active_workers (active_ff),
         .tok_in_valid   (tok_valid[g]),
         .tok_in_idx     (tok_idx[g]),
         .tok_in_time    (tok_time[g]),
         .tok_out_valid  (tok_valid[g+1]),
         .tok_out_idx    (tok_idx[g+1]),
         .tok_out_time   (tok_time[g+1]),
         .clear          (clear),
         .wr_en          (finish),
         .wr_idx         (tok_idx[WORKERS]),
         .wr_time        (new_time)
      );
   end

   always_comb begin
      accept = start && !busy_ff;
      clear  = accept && req_payload.new_batch;
      finish = tok_valid[WORKERS];

      sum      = {1'b0, tok_time[WORKERS]} + (TIME_W+1)'(dur_ff);
      new_time = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];

      worker_out = WORKER_W'(tok_idx[WORKERS]);

      busy_in   = busy_ff;
      launch_in = accept;
      dur_in    = dur_ff;
      active_in = csr_valid ? csr_data : active_ff;
      if (accept) begin
         busy_in = 1'b1;
         dur_in  = req_payload.duration;
      end else if (finish) begin
         busy_in = 1'b0;
      end

      rsp_valid_in      = finish;
      rsp_in            = rsp_ff;
      if (finish) begin
         rsp_in.worker     = worker_out;
         rsp_in.start_time = tok_time[WORKERS];
         rsp_in.saturated  = sum[TIME_W];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         launch_ff    <= 1'b0;
         active_ff    <= ACTIVE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         launch_ff    <= launch_in;
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      dur_ff <= dur_in;
      rsp_ff <= rsp_in;
   end

   assign busy        = busy_ff;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;
   assign csr_ready   = 1'b1;

   a_launch_busy : assert property (@(posedge clock) disable iff (reset)
      launch_ff |-> busy_ff)
      else $error("candidate launched while idle");

   a_finish_busy : assert property (@(posedge clock) disable iff (reset)
      finish |-> busy_ff)
      else $error("chain finished while idle");

   a_accept_busy : assert property (@(posedge clock) disable iff (reset)
      accept |=> (busy_ff && launch_ff))
      else $error("transfer did not start a dispatch");

   a_rsp_idle : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !busy_ff)
      else $error("result issued while still busy");

endmodule
`default_nettype wire

FILE: tb/efwd_dispatch_checker.sv
// Checker for earliest_free_worker_dispatch_top: tracks worker free times and the
// worker-count register, predicts each grant and compares it against rsp_payload.
// Depends on efwd_pkg.
module efwd_dispatch_checker #(
   parameter int WORKERS = efwd_pkg::WORKERS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic                          busy,
   input  efwd_pkg::req_type             req_payload,
   input  logic                          rsp_valid,
   input  efwd_pkg::rsp_type             rsp_payload,
   input  logic                          csr_valid,
   input  logic                          csr_ready,
   input  logic [efwd_pkg::ACTIVE_W-1:0] csr_data,
   output int                            mismatch_count,
   output int                            grants_pending
);

   logic [efwd_pkg::TIME_W-1:0]   free_at [WORKERS];
   logic [efwd_pkg::ACTIVE_W-1:0] pool_size;
   efwd_pkg::rsp_type             expected_grants [$];
   int                            errors = 0;

   function automatic efwd_pkg::rsp_type dispatch_job(efwd_pkg::req_type job);
      int                          n;
      int                          pick;
      logic [efwd_pkg::TIME_W:0]   sum;
      efwd_pkg::rsp_type           grant;
      if (job.new_batch) begin
         for (int i = 0; i < WORKERS; i++) free_at[i] = '0;
      end
      n = int'(pool_size);
      if (n == 0) n = 1;
      if (n > WORKERS) n = WORKERS;
      pick = 0;
      for (int i = 1; i < n; i++) begin
         if (free_at[i] < free_at[pick]) pick = i;
      end
      sum = {1'b0, free_at[pick]} + (efwd_pkg::TIME_W + 1)'(job.duration);
      grant.worker     = efwd_pkg::WORKER_W'(pick);
      grant.start_time = free_at[pick];
      grant.saturated  = sum > {1'b0, efwd_pkg::TIME_MAX};
      free_at[pick]    = grant.saturated ? efwd_pkg::TIME_MAX
                                         : sum[efwd_pkg::TIME_W-1:0];
      return grant;
   endfunction

   always @(posedge clock) begin
      efwd_pkg::rsp_type want;
      if (reset) begin
         for (int i = 0; i < WORKERS; i++) free_at[i] = '0;
         pool_size = efwd_pkg::ACTIVE_RESET;
         expected_grants.delete();
      end else begin
         if (csr_valid && csr_ready) pool_size = csr_data;
         if (rsp_valid) begin
            if (expected_grants.size() == 0) begin
               errors++;
               if (errors <= 10)
                  $display("unexpected grant: worker %0d start %0h sat %0b",
                           rsp_payload.worker, rsp_payload.start_time,
                           rsp_payload.saturated);
            end else begin
               want = expected_grants.pop_front();
               if (rsp_payload.worker !== want.worker ||
                   rsp_payload.start_time !== want.start_time ||
                   rsp_payload.saturated !== want.saturated) begin
                  errors++;
                  if (errors <= 10)
                     $display({"grant mismatch: expected worker %0d start %0h sat %0b,",
                               " got worker %0d start %0h sat %0b"},
                              want.worker, want.start_time, want.saturated,
                              rsp_payload.worker, rsp_payload.start_time,
                              rsp_payload.saturated);
               end
            end
         end
         if (start && !busy) expected_grants.push_back(dispatch_job(req_payload));
      end
      mismatch_count <= errors;
      grants_pending <= expected_grants.size();
   end

endmodule

FILE: tb/earliest_free_worker_dispatch_top_tb.sv
// Testbench top for earliest_free_worker_dispatch_top: drives jobs and worker-count
// writes, and reports the verdict from efwd_dispatch_checker.
// Depends on efwd_pkg, efwd_dispatch_checker and the block itself.
module earliest_free_worker_dispatch_top_tb;

   localparam int WORKERS = efwd_pkg::WORKERS_DEFAULT;
   localparam logic [efwd_pkg::DUR_W-1:0] DUR_MAX = '1;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          start = 1'b0;
   logic                          busy;
   efwd_pkg::req_type             req_payload = '0;
   logic                          rsp_valid;
   efwd_pkg::rsp_type             rsp_payload;
   logic                          csr_valid = 1'b0;
   logic                          csr_ready;
   logic [efwd_pkg::ACTIVE_W-1:0] csr_data = '0;
   int                            mismatch_count;
   int                            grants_pending;

   always #1 clock = ~clock;

   earliest_free_worker_dispatch_top #(.WORKERS(WORKERS)) dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_data    (csr_data)
   );

   efwd_dispatch_checker #(.WORKERS(WORKERS)) grant_check (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_payload    (req_payload),
      .rsp_valid      (rsp_valid),
      .rsp_payload    (rsp_payload),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_data       (csr_data),
      .mismatch_count (mismatch_count),
      .grants_pending (grants_pending)
   );

   task automatic offer_job(input logic [efwd_pkg::DUR_W-1:0] dur, input logic batch);
      start       <= 1'b1;
      req_payload <= '{duration: dur, new_batch: batch};
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic hold_sender(input int cycles);
      start       <= 1'b0;
      req_payload <= '{duration: $urandom, new_batch: 1'($urandom)};
      repeat (cycles) @(posedge clock);
   endtask

   task automatic wait_drained();
      start <= 1'b0;
      @(posedge clock);
      while (grants_pending != 0) @(posedge clock);
   endtask

   task automatic write_pool_size(input logic [efwd_pkg::ACTIVE_W-1:0] value);
      wait_drained();
      repeat (WORKERS + 4) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      csr_data  <= efwd_pkg::ACTIVE_W'($urandom);
   endtask

   function automatic logic [efwd_pkg::DUR_W-1:0] pick_duration();
      int bit_pos;
      bit_pos = $urandom_range(0, efwd_pkg::DUR_W - 1);
      case ($urandom_range(0, 5))
         0:       return $urandom_range(0, 15);
         1:       return DUR_MAX - $urandom_range(0, 15);
         2:       return $urandom_range(0, 1000);
         3:       return 32'd1 << bit_pos;
         4:       return ~(32'd1 << bit_pos);
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [efwd_pkg::ACTIVE_W-1:0] pick_pool_size();
      case ($urandom_range(0, 7))
         0:       return efwd_pkg::ACTIVE_W'(0);
         1:       return efwd_pkg::ACTIVE_W'(1);
         2:       return efwd_pkg::ACTIVE_W'(2);
         3:       return efwd_pkg::ACTIVE_W'(WORKERS);
         4:       return efwd_pkg::ACTIVE_W'(WORKERS + 1);
         5:       return '1;
         default: return efwd_pkg::ACTIVE_W'($urandom);
      endcase
   endfunction

   initial begin
      int sent;
      int phase_len;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      offer_job(0, 1'b1);
      offer_job(DUR_MAX, 1'b0);
      offer_job(1, 1'b0);
      offer_job(0, 1'b0);
      offer_job(32'h8000_0000, 1'b0);
      offer_job(7, 1'b1);
      offer_job(3, 1'b0);
      write_pool_size(efwd_pkg::ACTIVE_W'(0));
      offer_job(10, 1'b0);
      offer_job(20, 1'b0);
      write_pool_size('1);
      offer_job(5, 1'b0);
      offer_job(5, 1'b0);
      offer_job(DUR_MAX, 1'b0);
      write_pool_size(efwd_pkg::ACTIVE_W'(WORKERS + 1));
      offer_job(2, 1'b0);
      offer_job(9, 1'b0);
      write_pool_size(efwd_pkg::ACTIVE_W'(2));
      offer_job(4, 1'b0);
      offer_job(4, 1'b0);
      offer_job(1, 1'b0);
      write_pool_size(efwd_pkg::ACTIVE_W'(WORKERS));
      offer_job(0, 1'b0);
      offer_job(6, 1'b0);
      offer_job(6, 1'b0);

      write_pool_size(efwd_pkg::ACTIVE_W'(1));
      offer_job(DUR_MAX, 1'b1);
      offer_job(DUR_MAX, 1'b0);
      offer_job(0, 1'b0);
      offer_job(1, 1'b0);
      offer_job(DUR_MAX, 1'b0);
      write_pool_size(efwd_pkg::ACTIVE_W'(3));
      offer_job(DUR_MAX, 1'b0);
      offer_job(0, 1'b0);
      offer_job(12, 1'b0);
      write_pool_size(efwd_pkg::ACTIVE_W'(1));
      offer_job(0, 1'b0);

      sent = 0;
      while (sent < 615) begin
         write_pool_size(pick_pool_size());
         phase_len = $urandom_range(40, 120);
         if (phase_len > 615 - sent) phase_len = 615 - sent;
         repeat (phase_len) begin
            offer_job(pick_duration(), $urandom_range(0, 15) == 0);
            sent++;
            if (sent == 330) wait_drained();
            if ((sent < 200 || sent >= 320) && $urandom_range(0, 99) < 22)
               hold_sender($urandom_range(1, 40));
         end
      end

      wait_drained();
      repeat (WORKERS + 4) @(posedge clock);
      if (mismatch_count == 0 && grants_pending == 0) begin
         $display("earliest_free_worker_dispatch_top verification clean");
      end else begin
         $display("earliest_free_worker_dispatch_top verification failed");
      end
      $finish;
   end

   initial begin
      #12000000;
      $display("earliest_free_worker_dispatch_top verification failed");
      $finish;
   end

endmodule

FILE: filelist.f
hdl/efwd_pkg.sv
hdl/efwd_cell.sv
hdl/earliest_free_worker_dispatch_top.sv
tb/efwd_dispatch_checker.sv
tb/earliest_free_worker_dispatch_top_tb.sv
